// ===== hw/rtl/bcd_pkg.sv =====
// Shared types and constants of the blink code decoder.
// No dependencies; every other file of the block refers to this package.
package bcd_pkg;

    localparam int unsigned GapWidth   = 16;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned CodeWidth  = 8;
    localparam int unsigned KindWidth  = 2;
    localparam int unsigned AddrWidth  = 2;

    localparam logic [GapWidth-1:0]   GAP_SAT       = '1;
    localparam logic [CountWidth-1:0] PULSE_SAT     = '1;
    localparam logic [GapWidth-1:0]   RST_GAP_MIN   = 16'd200;
    localparam logic [GapWidth-1:0]   RST_GAP_MAX   = 16'd250;
    localparam logic [GapWidth-1:0]   RST_END_GAP   = 16'd500;
    localparam logic [KindWidth-1:0]  RST_CODE_KIND = 2'd1;

    localparam logic [AddrWidth-1:0] REG_DIGIT_GAP_MIN = 2'd0;
    localparam logic [AddrWidth-1:0] REG_DIGIT_GAP_MAX = 2'd1;
    localparam logic [AddrWidth-1:0] REG_END_GAP       = 2'd2;
    localparam logic [AddrWidth-1:0] REG_CODE_KIND     = 2'd3;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic EV_CODE = 1'b0;
    localparam logic EV_DONE = 1'b1;

    typedef struct packed {
        logic [GapWidth-1:0]  digit_gap_min;
        logic [GapWidth-1:0]  digit_gap_max;
        logic [GapWidth-1:0]  end_gap;
        logic [KindWidth-1:0] code_kind;
    } cfg_t;

    typedef struct packed {
        logic                 event_res;
        logic [CodeWidth-1:0] code;
        logic [KindWidth-1:0] kind;
    } result_t;

endpackage

// ===== hw/rtl/blink_code_decoder.sv =====
// Blink code decoder top level: decodes two-digit blink codes from line ticks.
// A result is registered in the result queue before it appears on m_tvalid.
// Throughput: one input beat per cycle; s_tready drops only while two results wait.
// Reset (rst_n low, asynchronous): registers take their defaults, the pass is
// finished so ticks are ignored until a start, and the result queue is empty.
module blink_code_decoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bcd_pkg::AddrWidth-1:0] cfg_addr,
    input  logic [bcd_pkg::GapWidth-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // level, then zero fill
    input  logic                          s_tuser,  // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,  // code, kind, then zero fill
    output logic                          m_tuser   // event_res
);

    bcd_pkg::cfg_t    cfg;
    logic             accept;
    logic             res_valid;
    bcd_pkg::result_t res;
    bcd_pkg::result_t out_res;

    assign accept = s_tvalid && s_tready;

    bcd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (accept),
        .op        (s_tuser),
        .level     (s_tdata[0]),
        .res_valid (res_valid),
        .res       (res)
    );

    bcd_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {6'b000000, out_res.kind, out_res.code};
    assign m_tuser = out_res.event_res;

endmodule

// ===== hw/rtl/bcd_cfg.sv =====
// Configuration register file of the blink code decoder.
// Depends on bcd_pkg.
module bcd_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bcd_pkg::AddrWidth-1:0] cfg_addr,
    input  logic [bcd_pkg::GapWidth-1:0]  cfg_wdata,
    output bcd_pkg::cfg_t                 cfg
);

    bcd_pkg::cfg_t cfg_reg;
    bcd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                bcd_pkg::REG_DIGIT_GAP_MIN: cfg_next.digit_gap_min = cfg_wdata;
                bcd_pkg::REG_DIGIT_GAP_MAX: cfg_next.digit_gap_max = cfg_wdata;
                bcd_pkg::REG_END_GAP:       cfg_next.end_gap       = cfg_wdata;
                bcd_pkg::REG_CODE_KIND:
                    cfg_next.code_kind = cfg_wdata[bcd_pkg::KindWidth-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.digit_gap_min <= bcd_pkg::RST_GAP_MIN;
            cfg_reg.digit_gap_max <= bcd_pkg::RST_GAP_MAX;
            cfg_reg.end_gap       <= bcd_pkg::RST_END_GAP;
            cfg_reg.code_kind     <= bcd_pkg::RST_CODE_KIND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/bcd_core.sv =====
// Tick decoder: pulse counting, gap timing, digit and code forming.
// Depends on bcd_pkg.
module bcd_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  bcd_pkg::cfg_t   cfg,
    input  logic            in_valid,
    input  logic            op,
    input  logic            level,
    output logic            res_valid,
    output bcd_pkg::result_t res
);

    logic [bcd_pkg::GapWidth-1:0]   gap_timer_reg,   gap_timer_next;
    logic                           prev_level_reg,  prev_level_next;
    logic [bcd_pkg::CountWidth-1:0] pulse_count_reg, pulse_count_next;
    logic [bcd_pkg::CountWidth-1:0] first_digit_reg, first_digit_next;
    logic                           digit_taken_reg, digit_taken_next;
    logic                           pass_done_reg,   pass_done_next;

    logic [bcd_pkg::GapWidth-1:0]  gap_inc;
    logic                          digit_hit;
    logic                          end_hit;
    logic [bcd_pkg::CodeWidth-1:0] code_val;

    assign gap_inc   = (gap_timer_reg == bcd_pkg::GAP_SAT) ? gap_timer_reg
                                                           : gap_timer_reg + 1'b1;
    assign digit_hit = (gap_inc >= cfg.digit_gap_min) && (gap_inc <= cfg.digit_gap_max)
                       && !digit_taken_reg;
    assign end_hit   = gap_inc >= cfg.end_gap;
    assign code_val  = {1'b0, first_digit_reg, 3'b000} + {3'b000, first_digit_reg, 1'b0}
                       + {4'b0000, pulse_count_reg};

    always_comb
    begin
        gap_timer_next   = gap_timer_reg;
        prev_level_next  = prev_level_reg;
        pulse_count_next = pulse_count_reg;
        first_digit_next = first_digit_reg;
        digit_taken_next = digit_taken_reg;
        pass_done_next   = pass_done_reg;
        res_valid        = 1'b0;
        res.event_res    = bcd_pkg::EV_CODE;
        res.code         = code_val;
        res.kind         = cfg.code_kind;
        if (in_valid)
        begin
            if (op == bcd_pkg::OP_START)
            begin
                pass_done_next  = 1'b0;
                gap_timer_next  = '0;
                prev_level_next = 1'b0;
            end
            else if (!pass_done_reg)
            begin
                prev_level_next = level;
                if (level)
                begin
                    if (!prev_level_reg && (pulse_count_reg != bcd_pkg::PULSE_SAT))
                    begin
                        pulse_count_next = pulse_count_reg + 1'b1;
                    end
                    gap_timer_next   = '0;
                    digit_taken_next = 1'b0;
                end
                else if (digit_hit)
                begin
                    digit_taken_next = 1'b1;
                    gap_timer_next   = '0;
                    pulse_count_next = '0;
                    if (first_digit_reg == '0)
                    begin
                        first_digit_next = pulse_count_reg;
                    end
                    else if (pulse_count_reg != '0)
                    begin
                        res_valid        = 1'b1;
                        first_digit_next = '0;
                    end
                end
                else
                begin
                    gap_timer_next = gap_inc;
                    if (end_hit)
                    begin
                        res_valid      = 1'b1;
                        res.event_res  = bcd_pkg::EV_DONE;
                        res.code       = '0;
                        pass_done_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_timer_reg   <= '0;
            prev_level_reg  <= 1'b0;
            pulse_count_reg <= '0;
            first_digit_reg <= '0;
            digit_taken_reg <= 1'b0;
            pass_done_reg   <= 1'b1;
        end
        else
        begin
            gap_timer_reg   <= gap_timer_next;
            prev_level_reg  <= prev_level_next;
            pulse_count_reg <= pulse_count_next;
            first_digit_reg <= first_digit_next;
            digit_taken_reg <= digit_taken_next;
            pass_done_reg   <= pass_done_next;
        end
    end

endmodule

// ===== hw/rtl/bcd_outq.sv =====
// Result register with a skid stage, two results deep.
// Depends on bcd_pkg.
module bcd_outq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bcd_pkg::result_t push_data,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output bcd_pkg::result_t out_data
);

    logic [1:0]       count_reg, count_next;
    bcd_pkg::result_t head_reg, head_next;
    bcd_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop      = out_valid && out_ready;
    assign has_room = count_reg != 2'd2;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        unique case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_next = push_data;
                end
                else if (push)
                begin
                    skid_next  = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next  = skid_reg;
                    count_next = 2'd1;
                end
            end
            default: count_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid = count_reg != 2'd0;
    assign out_data  = head_reg;

endmodule

// ===== hw/rtl/bcd_checker.sv =====
// Port-level checks of the blink code decoder, bound to the top level.
// Depends on bcd_pkg and blink_code_decoder.
module bcd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_done_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == bcd_pkg::EV_DONE) |-> m_tdata[7:0] == 8'd0)
        else $error("finished beat carries a nonzero code");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == bcd_pkg::EV_CODE)
        |-> (m_tdata[7:0] >= 8'd11) && (m_tdata[7:0] <= 8'd165))
        else $error("code beat out of the two-digit range");

endmodule

bind blink_code_decoder bcd_checker u_bcd_checker (.*);
